// ===== hdl/periodic_task_timer_table_core_macros.svh =====
// Assertion macros shared by the timer table modules.
`ifndef PERIODIC_TASK_TIMER_TABLE_CORE_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PTT_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define PTT_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== hdl/ptt_pkg.sv =====
// Package with result kinds, commands and controller types for the timer table.
`timescale 1ns / 1ps
package ptt_pkg;
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_STOP = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [2:0] KIND_ADDED = 3'd0;
  localparam logic [2:0] KIND_FULL  = 3'd1;
  localparam logic [2:0] KIND_FIRE  = 3'd2;
  localparam logic [2:0] KIND_DONE  = 3'd3;
  localparam logic [2:0] KIND_STOP  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_STOP,
    ST_READ,
    ST_VISIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic do_add;
    logic do_stop;
    logic clear_idx;
    logic step_idx;
    logic visit;
    logic emit_done;
  } ctrl_t;

  typedef struct packed {
    logic idx_last;
    logic out_busy;
  } stat_t;
endpackage

// ===== hdl/ptt_ram.sv =====
// Generic single port RAM with registered read.
`timescale 1ns / 1ps
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                              wdata,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/ptt_ctrl.sv =====
// Controller state machine that sequences add, stop and tick items.
`timescale 1ns / 1ps
module ptt_ctrl import ptt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  output logic       in_ready,
  input  stat_t      stat,
  output ctrl_t      ctrl
);
`include "periodic_task_timer_table_core_macros.svh"
  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !stat.out_busy) begin
          case (in_cmd)
            CMD_ADD:  state_next = ST_ADD;
            CMD_STOP: state_next = ST_STOP;
            CMD_TICK: state_next = ST_READ;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD, ST_STOP: state_next = ST_IDLE;
      ST_READ: state_next = ST_VISIT;
      ST_VISIT: begin
        if (!stat.out_busy) begin
          state_next = stat.idx_last ? ST_DONE : ST_READ;
        end
      end
      ST_DONE: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !stat.out_busy;
        ctrl.load = in_valid && !stat.out_busy;
        ctrl.clear_idx = 1'b1;
      end
      ST_ADD: ctrl.do_add = 1'b1;
      ST_STOP: ctrl.do_stop = 1'b1;
      ST_READ: ;
      ST_VISIT: begin
        ctrl.visit = !stat.out_busy;
        ctrl.step_idx = !stat.out_busy;
      end
      ST_DONE: ctrl.emit_done = !stat.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  `PTT_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == ST_IDLE)
  `PTT_ASSERT_NEXT(a_read_visit, clk, rst, state == ST_READ, state == ST_VISIT)
  `PTT_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1,
    $onehot0({ctrl.do_add, ctrl.do_stop, ctrl.visit, ctrl.emit_done}))
endmodule

// ===== hdl/ptt_datapath.sv =====
// Slot storage, due and drop tests, and the result register of the timer table.
`timescale 1ns / 1ps
module ptt_datapath import ptt_pkg::*; #(
  parameter int SLOTS = 16,
  parameter int ID_BITS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ctrl,
  output stat_t       stat,
  input  logic [31:0] now,
  input  logic [31:0] period,
  input  logic [31:0] first_delay,
  input  logic [31:0] repeat_limit,
  input  logic [31:0] lifetime,
  input  logic [15:0] stop_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [15:0] task_id,
  output logic        last
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW = TIME_BITS + 1;
  localparam int RW = ID_BITS + TIME_BITS + TW + TW + 64;

  logic [TIME_BITS-1:0] r_now, r_period, r_delay, r_life;
  logic [31:0] r_limit;
  logic [ID_BITS-1:0] r_sid, next_task_id;
  logic [SLOTS-1:0] slot_valid, slot_kill;
  logic [SLOTS-1:0] match_q;
  logic [ID_BITS-1:0] slot_id_q [SLOTS];
  logic [IW-1:0] idx;
  logic free_found;
  logic [IW-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_q[i] = slot_valid[i] && slot_id_q[i] == r_sid;
    end
  end

  logic we;
  logic [IW-1:0] addr;
  logic [RW-1:0] wdata, rdata;
  logic [ID_BITS-1:0] rd_id;
  logic [TIME_BITS-1:0] rd_period;
  logic [TW-1:0] rd_next, rd_dead;
  logic [31:0] rd_lim, rd_cnt;
  assign {rd_id, rd_period, rd_next, rd_dead, rd_lim, rd_cnt} = rdata;

  logic due, drop;
  logic [31:0] cnt_new;
  logic [TW-1:0] next_new;
  logic [TIME_BITS-1:0] r_period_sel;
  assign r_period_sel = rd_period;
  assign due = {1'b0, r_now} >= rd_next;
  assign cnt_new = due ? rd_cnt + 32'd1 : rd_cnt;
  assign next_new = due ? {1'b0, r_now} + {1'b0, r_period_sel} : rd_next;
  assign drop = slot_kill[idx] || (rd_lim != 32'd0 && cnt_new == rd_lim)
             || (rd_dead != '0 && {1'b0, r_now} > rd_dead);

  always_comb begin
    we = 1'b0;
    addr = idx;
    wdata = {rd_id, rd_period, next_new, rd_dead, rd_lim, cnt_new};
    if (ctrl.do_add) begin
      we = free_found;
      addr = free_idx;
      wdata = {next_task_id, r_period, {1'b0, r_now} + {1'b0, r_delay},
               (r_life != '0) ? {1'b0, r_now} + {1'b0, r_life} : TW'(0),
               r_limit, 32'd0};
    end else if (ctrl.visit) begin
      we = slot_valid[idx];
    end
  end

  ptt_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign stat.idx_last = idx == IW'(SLOTS - 1);
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      r_now <= TIME_BITS'(now);
      r_period <= TIME_BITS'(period);
      r_delay <= TIME_BITS'(first_delay);
      r_life <= TIME_BITS'(lifetime);
      r_limit <= repeat_limit;
      r_sid <= ID_BITS'(stop_id);
    end
    if (ctrl.do_add && free_found) slot_id_q[free_idx] <= next_task_id;
    if (ctrl.do_add) begin
      kind <= free_found ? KIND_ADDED : KIND_FULL;
      task_id <= free_found ? 16'(next_task_id) : 16'd0;
      last <= 1'b1;
    end else if (ctrl.do_stop) begin
      kind <= KIND_STOP;
      task_id <= 16'(r_sid);
      last <= 1'b1;
    end else if (ctrl.visit && slot_valid[idx] && due) begin
      kind <= KIND_FIRE;
      task_id <= 16'(rd_id);
      last <= 1'b0;
    end else if (ctrl.emit_done) begin
      kind <= KIND_DONE;
      task_id <= 16'd0;
      last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_kill <= '0;
      next_task_id <= '0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.do_add || ctrl.do_stop || ctrl.emit_done ||
          (ctrl.visit && slot_valid[idx] && due)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (ctrl.clear_idx) idx <= '0;
      else if (ctrl.step_idx) idx <= idx + IW'(1);
      if (ctrl.do_add && free_found) begin
        slot_valid[free_idx] <= 1'b1;
        slot_kill[free_idx] <= 1'b0;
        next_task_id <= next_task_id + ID_BITS'(1);
      end
      if (ctrl.do_stop) slot_kill <= slot_kill | match_q;
      if (ctrl.visit && slot_valid[idx] && drop) begin
        slot_valid[idx] <= 1'b0;
        slot_kill[idx] <= 1'b0;
      end
    end
  end

  `PTT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `PTT_ASSERT_IMP(a_no_over, clk, rst, out_valid && !out_ready,
    !(ctrl.do_add || ctrl.do_stop || ctrl.visit || ctrl.emit_done))
  `PTT_ASSERT_IMP(a_kill_valid, clk, rst, 1'b1, (slot_kill & ~slot_valid) == '0)
endmodule

// ===== hdl/periodic_task_timer_table_core.sv =====
// Top level of the periodic task timer table.
//  channel | signals                                      | direction
//  input   | in_valid in_ready cmd now period first_delay | in
//          | repeat_limit lifetime stop_id                |
//  output  | out_valid out_ready kind task_id last        | out
// Add and stop each pass through a state of their own and return to idle; a
// tick reads and then writes back each slot in turn over the one RAM port.
// Reset clears all valid and stop marks and the id counter at once.
// A stalled result holds the controller until it is taken.
`timescale 1ns / 1ps
module periodic_task_timer_table_core import ptt_pkg::*; #(
  parameter int SLOTS = 16,
  parameter int ID_BITS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] now,
  input  logic [31:0] period,
  input  logic [31:0] first_delay,
  input  logic [31:0] repeat_limit,
  input  logic [31:0] lifetime,
  input  logic [15:0] stop_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [15:0] task_id,
  output logic        last
);
  ctrl_t ctrl;
  stat_t stat;

  ptt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_cmd(cmd),
    .in_ready(in_ready), .stat(stat), .ctrl(ctrl)
  );

  ptt_datapath #(.SLOTS(SLOTS), .ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat), .now(now), .period(period),
    .first_delay(first_delay), .repeat_limit(repeat_limit), .lifetime(lifetime),
    .stop_id(stop_id), .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .task_id(task_id), .last(last)
  );
endmodule
